// ----- src/lfbp_pkg.sv -----
// Shared types and constants of the LSB-first bit packer.
`default_nettype none
package lfbp_pkg;

    // Field widths of the input and result items.
    localparam int unsigned CODE_BITS   = 16;
    localparam int unsigned LEN_BITS    = 5;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned PEND_BITS   = 7;
    localparam int unsigned CNT_BITS    = 3;
    localparam int unsigned ACC_BITS    = PEND_BITS + CODE_BITS;

    // Default widest code and the depth of the queue between front and back.
    localparam int unsigned DEF_CODE_WIDTH = 16;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_BITS      = $clog2(QUEUE_DEPTH);

    // One queue entry: one or two finished bytes, low byte first.
    typedef struct packed {
        logic [2*BYTE_BITS-1:0] bytes;
        logic                   two;
    } t_entry;

    // Write side of the queue as driven by the front part.
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    // Status of the queue as seen by both sides.
    typedef struct packed {
        logic   full;
        logic   empty;
        t_entry head;
    } t_qstat;

endpackage
`default_nettype wire

// ----- src/lfbp_channels.sv -----
// Handshake channel interfaces for code items and byte items.
`default_nettype none
interface lfbp_code_if;
    logic                            valid;
    logic                            ready;
    logic [lfbp_pkg::CODE_BITS-1:0]  code_value;
    logic [lfbp_pkg::LEN_BITS-1:0]   code_length;

    modport source (output valid, output code_value, output code_length, input ready);
    modport sink   (input valid, input code_value, input code_length, output ready);
endinterface

interface lfbp_byte_if;
    logic                            valid;
    logic                            ready;
    logic [lfbp_pkg::BYTE_BITS-1:0]  out_byte;
    logic                            last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/lfbp_front.sv -----
// Front part: accepts codes, merges them with the pending bits, queues whole bytes.
`default_nettype none
module lfbp_front #(
    parameter int unsigned CODE_WIDTH = lfbp_pkg::DEF_CODE_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lfbp_code_if.sink          i_code,
    input  wire lfbp_pkg::t_qstat i_qstat,
    output lfbp_pkg::t_push    o_push
);
    // Longest code actually used: the lesser of CODE_WIDTH and the field width.
    localparam int unsigned MaxLenInt =
        (CODE_WIDTH < lfbp_pkg::CODE_BITS) ? CODE_WIDTH : lfbp_pkg::CODE_BITS;
    localparam logic [lfbp_pkg::LEN_BITS-1:0] MaxLen = lfbp_pkg::LEN_BITS'(MaxLenInt);

    logic [lfbp_pkg::PEND_BITS-1:0] r_pend, n_pend;
    logic [lfbp_pkg::CNT_BITS-1:0]  r_cnt, n_cnt;

    logic                             accept;
    logic [lfbp_pkg::LEN_BITS-1:0]    len_sat;
    logic [lfbp_pkg::CODE_BITS-1:0]   code_mask;
    logic [lfbp_pkg::CODE_BITS-1:0]   code_m;
    logic [lfbp_pkg::ACC_BITS-1:0]    acc;
    logic [lfbp_pkg::LEN_BITS-1:0]    total;
    logic                             flush;

    // New items are taken whenever the queue has room.
    assign i_code.ready = !i_qstat.full;
    assign accept       = i_code.valid && !i_qstat.full;
    assign flush        = (i_code.code_length == '0);

    // Saturate the length, mask off code bits above it and merge above the pending bits.
    always_comb begin
        len_sat   = (i_code.code_length > MaxLen) ? MaxLen : i_code.code_length;
        code_mask = lfbp_pkg::CODE_BITS'(((lfbp_pkg::CODE_BITS+1)'(1) << len_sat) - 1'b1);
        code_m    = i_code.code_value & code_mask;
        acc       = (lfbp_pkg::ACC_BITS'(code_m) << r_cnt)
                    | lfbp_pkg::ACC_BITS'(r_pend);
        total     = lfbp_pkg::LEN_BITS'(r_cnt) + len_sat;
    end

    // Classify the item: how many bytes it completes and what stays pending.
    always_comb begin
        n_pend             = r_pend;
        n_cnt              = r_cnt;
        o_push.push        = 1'b0;
        o_push.entry.bytes = acc[2*lfbp_pkg::BYTE_BITS-1:0];
        o_push.entry.two   = 1'b0;
        if (accept) begin
            if (flush) begin
                // A partial byte goes out zero padded; the state is cleared.
                o_push.push        = (r_cnt != '0);
                o_push.entry.bytes = {{lfbp_pkg::BYTE_BITS{1'b0}}, 1'b0, r_pend};
                n_pend             = '0;
                n_cnt              = '0;
            end else if (total >= lfbp_pkg::LEN_BITS'(2*lfbp_pkg::BYTE_BITS)) begin
                o_push.push      = 1'b1;
                o_push.entry.two = 1'b1;
                n_pend = acc[2*lfbp_pkg::BYTE_BITS +: lfbp_pkg::PEND_BITS];
                n_cnt  = total[lfbp_pkg::CNT_BITS-1:0];
            end else if (total >= lfbp_pkg::LEN_BITS'(lfbp_pkg::BYTE_BITS)) begin
                o_push.push = 1'b1;
                n_pend = acc[lfbp_pkg::BYTE_BITS +: lfbp_pkg::PEND_BITS];
                n_cnt  = total[lfbp_pkg::CNT_BITS-1:0];
            end else begin
                n_pend = acc[lfbp_pkg::PEND_BITS-1:0];
                n_cnt  = total[lfbp_pkg::CNT_BITS-1:0];
            end
        end
    end

    // Pending bits and their count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end
endmodule
`default_nettype wire

// ----- src/lfbp_queue.sv -----
// Short queue of finished byte groups between the front and back parts.
`default_nettype none
module lfbp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lfbp_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output lfbp_pkg::t_qstat      o_qstat
);
    lfbp_pkg::t_entry r_mem [lfbp_pkg::QUEUE_DEPTH];

    logic [lfbp_pkg::QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [lfbp_pkg::QPTR_BITS:0]   r_count;
    logic                           do_push, do_pop;

    assign o_qstat.full  = (r_count == (lfbp_pkg::QPTR_BITS+1)'(lfbp_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.head  = r_mem[r_rd_ptr];
    assign do_push       = i_push.push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == lfbp_pkg::QPTR_BITS'(lfbp_pkg::QUEUE_DEPTH-1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == lfbp_pkg::QPTR_BITS'(lfbp_pkg::QUEUE_DEPTH-1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/lfbp_back.sv -----
// Back part: takes byte groups from the queue and sends them one byte per cycle while o_byte is ready.
`default_nettype none
module lfbp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lfbp_pkg::t_qstat i_qstat,
    output logic                  o_pop,
    lfbp_byte_if.source           o_byte
);
    logic                           r_valid, n_valid;
    logic [lfbp_pkg::BYTE_BITS-1:0] r_byte, n_byte;
    logic                           r_last, n_last;
    logic [lfbp_pkg::BYTE_BITS-1:0] r_hi, n_hi;
    logic                           r_hi_pend, n_hi_pend;
    logic                           free;

    assign o_byte.valid       = r_valid;
    assign o_byte.out_byte    = r_byte;
    assign o_byte.last_of_run = r_last;

    // The output register is free when empty or when its byte is taken now.
    assign free = !r_valid || o_byte.ready;

    // Load the high byte of a pair first, otherwise the next queue entry.
    always_comb begin
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_hi      = r_hi;
        n_hi_pend = r_hi_pend;
        o_pop     = 1'b0;
        if (free) begin
            if (r_hi_pend) begin
                n_valid   = 1'b1;
                n_byte    = r_hi;
                n_last    = 1'b1;
                n_hi_pend = 1'b0;
            end else if (!i_qstat.empty) begin
                o_pop     = 1'b1;
                n_valid   = 1'b1;
                n_byte    = i_qstat.head.bytes[lfbp_pkg::BYTE_BITS-1:0];
                n_last    = !i_qstat.head.two;
                n_hi      = i_qstat.head.bytes[lfbp_pkg::BYTE_BITS +: lfbp_pkg::BYTE_BITS];
                n_hi_pend = i_qstat.head.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Output register and the held second byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hi_pend <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_hi_pend <= n_hi_pend;
        end
        r_byte <= n_byte;
        r_last <= n_last;
        r_hi   <= n_hi;
    end
endmodule
`default_nettype wire

// ----- src/lsb_first_bit_packer.sv -----
// LSB-first variable-length bit packer: top level.
//
// i_code carries one code per item: code_value and code_length (1 to 16 bits, 0 = flush).
// Code bits are appended least significant bit first above the pending bits; each
// finished byte leaves on o_byte with out_byte and last_of_run, which marks the last
// byte caused by one code. A flush sends a partial byte zero padded and clears the
// pending bits; a flush with nothing pending sends nothing.
// The front part merges a code with the pending bits in the cycle it is accepted and
// writes the finished bytes, one or two, into a two-entry queue. The back part reads
// the queue into the output register, one byte per cycle while the receiver is ready.
// A first byte passes through the queue and then the output register before it is valid on o_byte.
// Throughput: one code per cycle while codes yield at most one byte and the receiver is ready;
// a code that yields two bytes holds the output channel for both of them, so codes that
// complete two bytes each are limited by the one-byte-per-cycle output register.
// When the receiver stalls, the output holds and the queue fills; i_code.ready drops
// once the queue is full. Reset empties the queue and output and clears pending bits.
`default_nettype none
module lsb_first_bit_packer #(
    parameter int unsigned CODE_WIDTH = lfbp_pkg::DEF_CODE_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lfbp_code_if.sink   i_code,
    lfbp_byte_if.source o_byte
);
    lfbp_pkg::t_push  push;
    lfbp_pkg::t_qstat qstat;
    logic             pop;

    lfbp_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (i_code),
        .i_qstat (qstat),
        .o_push  (push)
    );

    lfbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat)
    );

    lfbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );
endmodule
`default_nettype wire
